### sv/password_composition_checker_core_macros.svh
// ----------------------------------------------------------------------------
// Password composition checker assertion macros
// Shared shorthand for the concurrent checks of the checker block.
// ----------------------------------------------------------------------------
`ifndef PASSWORD_COMPOSITION_CHECKER_CORE_MACROS_SVH
`define PASSWORD_COMPOSITION_CHECKER_CORE_MACROS_SVH

// Overlapping implication, sampled on the rising clock edge, off in reset.
`define PCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pcc: implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pcc: next-cycle check failed");

`endif

### sv/pcc_pkg.sv
// ----------------------------------------------------------------------------
// Password composition checker package
// Types, codes, register defaults and small helper functions.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int MAX_LEN = 255;
    localparam logic [7:0] LEN_CAP = (MAX_LEN < 255) ? 8'(MAX_LEN) : 8'd255;

    localparam logic [7:0] MIN_LENGTH_FLOOR = 8'd5;
    localparam logic [2:0] CLASS_LIMIT      = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MIN_LENGTH        = 3'd0;
    localparam t_cfg_idx CFG_CLASS_CREDITS     = 3'd1;
    localparam t_cfg_idx CFG_MIN_CLASSES       = 3'd2;
    localparam t_cfg_idx CFG_MAX_SAME_RUN      = 3'd3;
    localparam t_cfg_idx CFG_MAX_MONOTONIC_RUN = 3'd4;
    localparam t_cfg_idx CFG_MAX_CLASS_RUN     = 3'd5;

    localparam logic [7:0]  RST_MIN_LENGTH    = 8'd9;
    localparam logic [31:0] RST_CLASS_CREDITS = 32'h0101_0101;

    typedef enum logic [1:0] {
        CLS_DIGIT = 2'd0,
        CLS_UPPER = 2'd1,
        CLS_LOWER = 2'd2,
        CLS_OTHER = 2'd3
    } t_cls;

    typedef enum logic [2:0] {
        V_PASS    = 3'd0,
        V_SIMPLE  = 3'd1,
        V_CLASSES = 3'd2,
        V_REPEAT  = 3'd3,
        V_MONO    = 3'd4
    } t_verdict;

    typedef struct packed {
        logic mono;
        logic same;
        logic cls;
    } t_fail;

    // Per-password totals handed from the byte stage to the verdict stage.
    typedef struct packed {
        logic [7:0]      len;
        logic [3:0][7:0] cnt;
        t_fail           fail;
    } t_snap;

    typedef struct packed {
        logic [7:0] run;
        logic       trip;
    } t_bump;

    function automatic t_cls class_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return CLS_DIGIT;
        if (c >= 8'h41 && c <= 8'h5A) return CLS_UPPER;
        if (c >= 8'h61 && c <= 8'h7A) return CLS_LOWER;
        return CLS_OTHER;
    endfunction

    // Extend a run by one; trip when the uncapped length passes a nonzero limit.
    function automatic t_bump bump(input logic [7:0] run, input logic [7:0] limit);
        logic [8:0] nx;
        t_bump      res;
        nx       = {1'b0, run} + 9'd1;
        res.trip = (limit != 8'd0) && (nx > {1'b0, limit});
        res.run  = nx[8] ? 8'hFF : nx[7:0];
        return res;
    endfunction

endpackage

### sv/pcc_in_if.sv
// ----------------------------------------------------------------------------
// Password byte channel
// Valid/ready channel that carries one password byte and its final-byte flag.
// ----------------------------------------------------------------------------
interface pcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

### sv/pcc_out_if.sv
// ----------------------------------------------------------------------------
// Password verdict channel
// Valid/ready channel that carries the verdict and length of one password.
// ----------------------------------------------------------------------------
interface pcc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [7:0] pw_length;

    modport source (output valid, output verdict, output pw_length, input ready);
    modport sink   (input valid, input verdict, input pw_length, output ready);
endinterface

### sv/password_composition_checker_core.sv
// ----------------------------------------------------------------------------
// Password composition checker
// Streams a password byte by byte and reports its strength verdict.
// ----------------------------------------------------------------------------
// The block takes one password byte per cycle on i_in unless it stalls, and
// keeps per-password counts and run lengths in registers; every byte transfer
// updates them, so bytes may arrive back to back without a gap, also across
// the end of one password and the start of the next. The transfer of a byte
// flagged last hands the totals to a verdict register stage, which passes the
// verdict and password length on to the o_out result register. One finished
// password may wait in each of the two stages, so input stalls only when both
// are full and the result is not taken. The verdict is the first failure of:
// too simple, too few classes, repeated bytes, monotonic sequence. The user
// must write configuration through i_cfg_we / i_cfg_idx / i_cfg_wdata only
// while no password is in flight; the block itself does not enforce this.
module password_composition_checker_core
    import pcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    pcc_in_if.sink                i_in,
    pcc_out_if.source             o_out
);

    // Configuration registers.
    logic [7:0]  r_min_length;
    logic [31:0] r_class_credits;
    logic [2:0]  r_min_classes;
    logic [7:0]  r_max_same_run;
    logic [7:0]  r_max_mono_run;
    logic [7:0]  r_max_class_run;

    // Per-password state.
    logic [7:0]      r_byte_count, n_byte_count;
    logic [3:0][7:0] r_cls_cnt, n_cls_cnt;
    logic [7:0]      r_prev_ch;
    t_cls            r_prev_cls;
    logic [7:0]      r_cls_run, n_cls_run;
    logic [7:0]      r_same_run, n_same_run;
    logic [7:0]      r_up_run, n_up_run;
    logic [7:0]      r_down_run, n_down_run;
    t_fail           r_fail, n_fail;

    // Verdict stage and result register.
    logic     r_fin_valid;
    t_snap    r_fin;
    logic     r_out_valid;
    t_verdict r_verdict, n_verdict;
    logic [7:0] r_out_len;

    logic  w_in_accept;
    logic  w_fin_move;
    logic  w_first;
    t_cls  w_cls;
    t_bump w_cls_bump;
    t_bump w_same_bump;
    t_bump w_up_bump;
    t_bump w_down_bump;
    logic  w_step_up;
    logic  w_step_down;

    logic [7:0] w_base;
    logic [8:0] w_credit_sum;
    logic [2:0] w_present;
    logic [2:0] w_need;
    logic       w_short_req;
    logic       w_weak;
    logic [7:0] w_cr;
    logic [7:0] w_cnt;
    logic [7:0] w_take;
    logic [8:0] w_req;

    assign w_in_accept = i_in.valid && i_in.ready;
    assign w_fin_move  = r_fin_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_fin_valid || w_fin_move;

    assign o_out.valid     = r_out_valid;
    assign o_out.verdict   = r_verdict;
    assign o_out.pw_length = r_out_len;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length    <= RST_MIN_LENGTH;
            r_class_credits <= RST_CLASS_CREDITS;
            r_min_classes   <= 3'd0;
            r_max_same_run  <= 8'd0;
            r_max_mono_run  <= 8'd0;
            r_max_class_run <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_LENGTH:        r_min_length    <= i_cfg_wdata[7:0];
                CFG_CLASS_CREDITS:     r_class_credits <= i_cfg_wdata[31:0];
                CFG_MIN_CLASSES:       r_min_classes   <= i_cfg_wdata[2:0];
                CFG_MAX_SAME_RUN:      r_max_same_run  <= i_cfg_wdata[7:0];
                CFG_MAX_MONOTONIC_RUN: r_max_mono_run  <= i_cfg_wdata[7:0];
                CFG_MAX_CLASS_RUN:     r_max_class_run <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // ---------------- per-byte update ----------------
    assign w_first = (r_byte_count == 8'd0);
    assign w_cls   = class_of(i_in.ch);

    // Steps compare as signed bytes, so there is no step across 0x7F / 0x80.
    assign w_step_up   = (i_in.ch == r_prev_ch + 8'd1) && (r_prev_ch != 8'h7F);
    assign w_step_down = (i_in.ch == r_prev_ch - 8'd1) && (r_prev_ch != 8'h80);

    assign w_cls_bump  = bump(r_cls_run, r_max_class_run);
    assign w_same_bump = bump(r_same_run, r_max_same_run);
    assign w_up_bump   = bump(r_up_run, r_max_mono_run);
    assign w_down_bump = bump(r_down_run, r_max_mono_run);

    always_comb begin
        n_fail = r_fail;

        for (int k = 0; k < 4; k++) begin
            n_cls_cnt[k] = r_cls_cnt[k];
            if ((w_cls == t_cls'(k)) && (r_cls_cnt[k] != 8'hFF)) begin
                n_cls_cnt[k] = r_cls_cnt[k] + 8'd1;
            end
        end

        if (!w_first && (w_cls == r_prev_cls)) begin
            n_cls_run  = w_cls_bump.run;
            n_fail.cls = r_fail.cls | w_cls_bump.trip;
        end else begin
            n_cls_run = 8'd1;
        end

        if (!w_first && (i_in.ch == r_prev_ch)) begin
            n_same_run  = w_same_bump.run;
            n_fail.same = r_fail.same | w_same_bump.trip;
        end else begin
            n_same_run = 8'd1;
        end

        n_up_run   = r_up_run;
        n_down_run = r_down_run;
        if (!w_first) begin
            if (w_step_up) begin
                n_up_run    = w_up_bump.run;
                n_down_run  = 8'd1;
                n_fail.mono = n_fail.mono | w_up_bump.trip;
            end else if (w_step_down) begin
                n_down_run  = w_down_bump.run;
                n_up_run    = 8'd1;
                n_fail.mono = n_fail.mono | w_down_bump.trip;
            end else begin
                n_up_run   = 8'd1;
                n_down_run = 8'd1;
            end
        end

        n_byte_count = (r_byte_count < LEN_CAP) ? r_byte_count + 8'd1 : r_byte_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 8'd0;
            r_cls_cnt    <= '0;
            r_prev_ch    <= 8'd0;
            r_cls_run    <= 8'd0;
            r_same_run   <= 8'd0;
            r_up_run     <= 8'd1;
            r_down_run   <= 8'd1;
            r_fail       <= '0;
        end else if (w_in_accept) begin
            if (i_in.last) begin
                r_byte_count <= 8'd0;
                r_cls_cnt    <= '0;
                r_prev_ch    <= 8'd0;
                r_cls_run    <= 8'd0;
                r_same_run   <= 8'd0;
                r_up_run     <= 8'd1;
                r_down_run   <= 8'd1;
                r_fail       <= '0;
            end else begin
                r_byte_count <= n_byte_count;
                r_cls_cnt    <= n_cls_cnt;
                r_prev_ch    <= i_in.ch;
                r_cls_run    <= n_cls_run;
                r_same_run   <= n_same_run;
                r_up_run     <= n_up_run;
                r_down_run   <= n_down_run;
                r_fail       <= n_fail;
            end
        end
    end

    // The previous class is only looked at once a byte of this password is in.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_prev_cls <= w_cls;
        end
    end

    // ---------------- verdict stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (w_in_accept && i_in.last) begin
            r_fin_valid <= 1'b1;
        end else if (w_fin_move) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && i_in.last) begin
            r_fin.len  <= n_byte_count;
            r_fin.cnt  <= n_cls_cnt;
            r_fin.fail <= n_fail;
        end
    end

    // A nonnegative credit lets up to that many bytes of a class count twice;
    // a negative one asks for at least its magnitude of bytes of that class.
    always_comb begin
        w_base       = (r_min_length < MIN_LENGTH_FLOOR) ? MIN_LENGTH_FLOOR : r_min_length;
        w_credit_sum = 9'd0;
        w_present    = 3'd0;
        w_short_req  = 1'b0;
        w_cr         = 8'd0;
        w_cnt        = 8'd0;
        w_take       = 8'd0;
        w_req        = 9'd0;
        for (int k = 0; k < 4; k++) begin
            w_cr  = r_class_credits[8*k +: 8];
            w_cnt = r_fin.cnt[k];
            if (!w_cr[7]) begin
                w_take       = (w_cnt < w_cr) ? w_cnt : w_cr;
                w_credit_sum = w_credit_sum + {1'b0, w_take};
            end else begin
                w_req = 9'd0 - {w_cr[7], w_cr};
                if ({1'b0, w_cnt} < w_req) begin
                    w_short_req = 1'b1;
                end
            end
            if (w_cnt != 8'd0) begin
                w_present = w_present + 3'd1;
            end
        end

        w_need = (r_min_classes > CLASS_LIMIT) ? CLASS_LIMIT : r_min_classes;
        w_weak = r_fin.fail.cls || w_short_req
                 || ({2'b00, w_base} > ({1'b0, w_credit_sum} + {2'b00, r_fin.len}));

        if (w_weak) begin
            n_verdict = V_SIMPLE;
        end else if (w_present < w_need) begin
            n_verdict = V_CLASSES;
        end else if (r_fin.fail.same) begin
            n_verdict = V_REPEAT;
        end else if (r_fin.fail.mono) begin
            n_verdict = V_MONO;
        end else begin
            n_verdict = V_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_move) begin
            r_verdict <= n_verdict;
            r_out_len <= r_fin.len;
        end
    end

endmodule

### sv/pcc_checker.sv
// ----------------------------------------------------------------------------
// Password composition checker port checks
// Concurrent checks on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "password_composition_checker_core_macros.svh"

module pcc_checker
    import pcc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_verdict,
    input logic [7:0] i_pw_length
);

    // A waiting result keeps its payload until it is transferred.
    `PCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_verdict) && $stable(i_pw_length))

    // A fresh result follows the transfer of a final byte, by way of the verdict stage and the result register.
    `PCC_ASSERT_IMPL(a_rise_after_last, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready && i_in_last, 2))

    // With the result register empty, the verdict stage can always drain.
    `PCC_ASSERT_IMPL(a_ready_when_out_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // Every password holds at least one byte and gets a defined verdict.
    `PCC_ASSERT_IMPL(a_result_sane, i_clk, i_rst_n, i_out_valid, (i_pw_length != 8'd0) && (i_verdict <= V_MONO))

endmodule

bind password_composition_checker_core pcc_checker u_pcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_verdict   (o_out.verdict),
    .i_pw_length (o_out.pw_length)
);

### tb/pcc_score_pkg.sv
// ----------------------------------------------------------------------------
// Password checker scoreboard
// Follows every password byte sent into the checker with its own copy of the
// registers and per-password state, predicts the verdict and length of each
// finished password and compares the results of the block against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcc_score_pkg;
    import pcc_pkg::*;

    typedef struct packed {
        t_verdict   verdict;
        logic [7:0] pw_length;
    } t_outcome;

    class verdict_scoreboard;
        // Register copies.
        logic [7:0]  need_len;
        logic [31:0] credit_bytes;
        logic [2:0]  need_kinds;
        logic [7:0]  repeat_limit;
        logic [7:0]  mono_limit;
        logic [7:0]  kind_limit;

        // Per-password state.
        int unsigned pw_len;
        int unsigned per_class [4];
        logic [7:0]  last_ch;
        t_cls        last_cls;
        int unsigned kind_run;
        int unsigned repeat_run;
        int unsigned rise_run;
        int unsigned fall_run;
        bit          kind_trip;
        bit          repeat_trip;
        bit          mono_trip;

        t_outcome    pending_verdicts [$];
        int unsigned mismatches;
        int unsigned passwords_seen;

        function new();
            need_len     = RST_MIN_LENGTH;
            credit_bytes = RST_CLASS_CREDITS;
            need_kinds   = '0;
            repeat_limit = '0;
            mono_limit   = '0;
            kind_limit   = '0;
            mismatches     = 0;
            passwords_seen = 0;
            clear_password();
        endfunction

        function void clear_password();
            pw_len = 0;
            foreach (per_class[k]) per_class[k] = 0;
            last_ch     = '0;
            last_cls    = CLS_OTHER;
            kind_run    = 0;
            repeat_run  = 0;
            rise_run    = 1;
            fall_run    = 1;
            kind_trip   = 1'b0;
            repeat_trip = 1'b0;
            mono_trip   = 1'b0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                CFG_MIN_LENGTH:        need_len     = data[7:0];
                CFG_CLASS_CREDITS:     credit_bytes = data;
                CFG_MIN_CLASSES:       need_kinds   = data[2:0];
                CFG_MAX_SAME_RUN:      repeat_limit = data[7:0];
                CFG_MAX_MONOTONIC_RUN: mono_limit   = data[7:0];
                CFG_MAX_CLASS_RUN:     kind_limit   = data[7:0];
                default: ;
            endcase
        endfunction

        function t_cls classify(logic [7:0] c);
            if (c >= "0" && c <= "9") return CLS_DIGIT;
            if (c >= "A" && c <= "Z") return CLS_UPPER;
            if (c >= "a" && c <= "z") return CLS_LOWER;
            return CLS_OTHER;
        endfunction

        // The trip test uses the uncapped length, so a run held at 255
        // still trips a limit of 255.
        function int unsigned extend_run(int unsigned run, logic [7:0] limit,
                                         inout bit trip);
            int unsigned nxt;
            nxt = run + 1;
            if (limit != 0 && nxt > limit) trip = 1'b1;
            return (nxt > 255) ? 255 : nxt;
        endfunction

        function t_verdict grade_password();
            int          size;
            int          credit;
            int          cnt;
            int          k;
            int unsigned present;
            int unsigned need;
            bit          too_simple;
            size       = (need_len < MIN_LENGTH_FLOOR) ? int'(MIN_LENGTH_FLOOR) : int'(need_len);
            too_simple = kind_trip;
            present    = 0;
            for (k = 0; k < 4; k++) begin
                credit = int'($signed(credit_bytes[8*k +: 8]));
                cnt    = int'(per_class[k]);
                if (credit >= 0) begin
                    size -= (cnt < credit) ? cnt : credit;
                end else if (cnt < -credit) begin
                    too_simple = 1'b1;
                end
                if (cnt != 0) present++;
            end
            if (!too_simple && size > int'(pw_len)) too_simple = 1'b1;
            if (too_simple) return V_SIMPLE;
            need = (need_kinds > CLASS_LIMIT) ? CLASS_LIMIT : need_kinds;
            if (present < need) return V_CLASSES;
            if (repeat_trip) return V_REPEAT;
            if (mono_trip) return V_MONO;
            return V_PASS;
        endfunction

        // Called for every accepted byte transfer.
        function void note_byte(logic [7:0] ch, logic last);
            t_cls     cls;
            bit       first;
            int       cur;
            int       prv;
            t_outcome res;
            cls   = classify(ch);
            first = (pw_len == 0);
            if (per_class[cls] < 255) per_class[cls]++;
            if (!first && cls == last_cls) begin
                kind_run = extend_run(kind_run, kind_limit, kind_trip);
            end else begin
                kind_run = extend_run(0, kind_limit, kind_trip);
            end
            if (!first && ch == last_ch) begin
                repeat_run = extend_run(repeat_run, repeat_limit, repeat_trip);
            end else begin
                repeat_run = 1;
            end
            if (!first) begin
                // Steps are taken on signed bytes, so 0x7F and 0x80 are not neighbors.
                cur = int'($signed(ch));
                prv = int'($signed(last_ch));
                if (cur == prv + 1) begin
                    rise_run = extend_run(rise_run, mono_limit, mono_trip);
                    fall_run = 1;
                end else if (cur == prv - 1) begin
                    fall_run = extend_run(fall_run, mono_limit, mono_trip);
                    rise_run = 1;
                end else begin
                    rise_run = 1;
                    fall_run = 1;
                end
            end
            if (pw_len < LEN_CAP) pw_len++;
            last_ch  = ch;
            last_cls = cls;
            if (last) begin
                res.verdict   = grade_password();
                res.pw_length = 8'(pw_len);
                pending_verdicts.push_back(res);
                clear_password();
            end
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        // Called for every accepted result transfer.
        function void check_verdict(logic [2:0] verdict, logic [7:0] pw_length);
            t_outcome exp;
            passwords_seen++;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("result %0d with none expected: verdict %0d length %0d",
                                 passwords_seen, verdict, pw_length));
                return;
            end
            exp = pending_verdicts.pop_front();
            if (verdict !== exp.verdict || pw_length !== exp.pw_length) begin
                report($sformatf({"result %0d mismatch: expected verdict %0d length %0d,",
                                  " got verdict %0d length %0d"},
                                 passwords_seen, exp.verdict, exp.pw_length,
                                 verdict, pw_length));
            end
        endfunction

        function int unsigned outstanding();
            return pending_verdicts.size();
        endfunction
    endclass

endpackage

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Password composition checker testbench
// Streams directed and random passwords through the checker under several
// register settings, with bursty input and a stalling result sink, and checks
// every verdict and length against a scoreboard prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import pcc_pkg::*;
    import pcc_score_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned TAIL_CYCLES  = 8;

    typedef enum int unsigned {
        STEP_REPEAT, STEP_UP, STEP_DOWN, STEP_DIGIT,
        STEP_UPPER, STEP_LOWER, STEP_OTHER, STEP_ANY
    } t_step;

    typedef enum int unsigned { LONG_SAME, LONG_UP, LONG_DOWN } t_long;

    typedef enum int unsigned { SINK_OPEN, SINK_MOSTLY, SINK_COIN, SINK_BURSTY } t_sink;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    pcc_in_if  in_ch ();
    pcc_out_if out_ch ();

    password_composition_checker_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    verdict_scoreboard sb = new();

    int unsigned bytes_sent = 0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        in_ch.valid <= 1'b1;
        in_ch.ch    <= b;
        in_ch.last  <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    // Bursts of random length separated by short gaps; some bursts are long.
    task automatic sender_gap();
        int unsigned gap;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 6);
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
    endtask

    task automatic write_settings(input logic [7:0] min_len, input logic [31:0] credits,
                                  input logic [2:0] kinds, input logic [7:0] same_lim,
                                  input logic [7:0] mono_lim, input logic [7:0] kind_lim);
        write_reg(CFG_MIN_LENGTH,        {24'd0, min_len});
        write_reg(CFG_CLASS_CREDITS,     credits);
        write_reg(CFG_MIN_CLASSES,       {29'd0, kinds});
        write_reg(CFG_MAX_SAME_RUN,      {24'd0, same_lim});
        write_reg(CFG_MAX_MONOTONIC_RUN, {24'd0, mono_lim});
        write_reg(CFG_MAX_CLASS_RUN,     {24'd0, kind_lim});
        i_cfg_we <= 1'b0;
    endtask

    // Stop sending and wait until every verdict is back and the pipe is quiet.
    task automatic settle();
        if (in_ch.valid) in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_limit();
        case ($urandom_range(5))
            0, 1:    return 8'd0;
            2:       return 8'($urandom_range(1, 4));
            3:       return 8'($urandom_range(5, 12));
            4:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic random_settings();
        logic [7:0]  min_len;
        logic [31:0] credits;
        int          k;
        case ($urandom_range(4))
            0:       min_len = 8'($urandom_range(0, 4));
            1:       min_len = MIN_LENGTH_FLOOR;
            2:       min_len = 8'($urandom_range(6, 16));
            3:       min_len = 8'd255;
            default: min_len = 8'($urandom_range(255));
        endcase
        for (k = 0; k < 4; k++) begin
            case ($urandom_range(6))
                0:       credits[8*k +: 8] = 8'd0;
                1:       credits[8*k +: 8] = 8'($urandom_range(1, 4));
                2:       credits[8*k +: 8] = 8'(256 - $urandom_range(1, 3));
                3:       credits[8*k +: 8] = 8'h7F;
                4:       credits[8*k +: 8] = 8'h80;
                default: credits[8*k +: 8] = 8'($urandom);
            endcase
        end
        write_settings(min_len, credits, 3'($urandom_range(7)),
                       pick_limit(), pick_limit(), pick_limit());
    endtask

    // Streaks of one kind of step build up class, repeat and monotonic runs.
    task automatic send_password(input int unsigned n);
        logic [7:0]  b;
        t_step       op;
        int unsigned streak;
        int unsigned i;
        b      = 8'($urandom);
        op     = STEP_ANY;
        streak = 0;
        for (i = 0; i < n; i++) begin
            if (streak == 0) begin
                op     = t_step'($urandom_range(STEP_ANY));
                streak = $urandom_range(1, 8);
            end
            streak--;
            case (op)
                STEP_REPEAT: ;
                STEP_UP:     b = b + 8'd1;
                STEP_DOWN:   b = b - 8'd1;
                STEP_DIGIT:  b = 8'("0" + $urandom_range(9));
                STEP_UPPER:  b = 8'("A" + $urandom_range(25));
                STEP_LOWER:  b = 8'("a" + $urandom_range(25));
                STEP_OTHER:  b = $urandom_range(1) ? 8'(8'h21 + $urandom_range(14))
                                                   : 8'(8'h80 + $urandom_range(127));
                default:     b = 8'($urandom);
            endcase
            send_byte(b, i == n - 1);
            sender_gap();
        end
    endtask

    // Long passwords drive the length counter and the runs into saturation.
    task automatic send_long_password();
        logic [7:0]  b;
        t_long       kind;
        int unsigned n;
        int unsigned i;
        kind = t_long'($urandom_range(LONG_DOWN));
        n    = $urandom_range(256, 300);
        case (kind)
            LONG_UP:   b = 8'h80;
            LONG_DOWN: b = 8'h7F;
            default:   b = 8'($urandom);
        endcase
        for (i = 0; i < n; i++) begin
            send_byte(b, i == n - 1);
            sender_gap();
            if (kind == LONG_UP) b = b + 8'd1;
            else if (kind == LONG_DOWN) b = b - 8'd1;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned count;
        int unsigned p;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_MIN_LENGTH;
        i_cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.ch    <= 8'd0;
        in_ch.last  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values: a lone zero byte, then a mixed password.
        send_byte(8'h00, 1'b1);
        send_byte("A", 1'b0);
        send_byte("b", 1'b0);
        send_byte("1", 1'b0);
        send_byte("!", 1'b0);
        send_byte("x", 1'b0);
        send_byte("y", 1'b0);
        send_byte("z", 1'b0);
        send_byte("9", 1'b0);
        send_byte("Q", 1'b1);
        settle();

        // Length floor, class cap above four, tight run limits, signed wrap.
        write_settings(8'd0, 32'h80FF_7F00, 3'd7, 8'd1, 8'd1, 8'd1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();

        // Largest settings and all credits negative.
        write_settings(8'd255, 32'hFFFF_FFFF, 3'd4, 8'd255, 8'd255, 8'd255);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte("c", 1'b0);
        send_byte("B", 1'b0);
        send_byte("0", 1'b1);
        settle();

        // No credits, small limits: a repeated byte run.
        write_settings(8'd5, 32'h0000_0000, 3'd2, 8'd2, 8'd3, 8'd0);
        send_byte("x", 1'b0);
        send_byte("a", 1'b0);
        send_byte("a", 1'b0);
        send_byte("a", 1'b0);
        send_byte("1", 1'b0);
        send_byte("2", 1'b1);
        settle();

        count = bytes_sent;
        while (bytes_sent - count < RANDOM_ITEMS) begin
            random_settings();
            for (p = $urandom_range(4, 16); p != 0; p--) begin
                if ($urandom_range(59) == 0) begin
                    send_long_password();
                end else if ($urandom_range(3) == 0) begin
                    send_password($urandom_range(1, 4));
                end else begin
                    send_password($urandom_range(5, 20));
                end
            end
            settle();
        end

        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink: switches between stall patterns and checks each transfer.
    // ------------------------------------------------------------------
    initial begin : result_sink
        t_sink       mode;
        int unsigned mode_left;
        int unsigned stall_left;
        mode       = SINK_OPEN;
        mode_left  = 0;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                sb.check_verdict(out_ch.verdict, out_ch.pw_length);
            end
            if (mode_left == 0) begin
                mode      = t_sink'($urandom_range(SINK_BURSTY));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                SINK_OPEN:   out_ch.ready <= 1'b1;
                SINK_MOSTLY: out_ch.ready <= ($urandom_range(3) != 0);
                SINK_COIN:   out_ch.ready <= 1'($urandom_range(1));
                default: begin
                    if (stall_left != 0) begin
                        stall_left--;
                        out_ch.ready <= 1'b0;
                    end else if ($urandom_range(7) == 0) begin
                        stall_left = $urandom_range(1, 12);
                        out_ch.ready <= 1'b0;
                    end else begin
                        out_ch.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Ends the run if no transfer and no register write happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (in_ch.valid && in_ch.ready)
                || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

### filelist.f
+incdir+sv
sv/pcc_pkg.sv
sv/pcc_in_if.sv
sv/pcc_out_if.sv
sv/password_composition_checker_core.sv
sv/pcc_checker.sv
tb/pcc_score_pkg.sv
tb/tb_top.sv
